FILE: rtl/fvn3d_pkg.sv
// shared types, constants and the cosine weight table for the fractal value noise block
// no dependencies
package fvn3d_pkg;

    localparam int MAX_OCTAVES       = 16;
    localparam int COS_TABLE_ENTRIES = 256;
    localparam int IDX_W             = $clog2(COS_TABLE_ENTRIES);
    localparam int OCT_W             = $clog2(MAX_OCTAVES + 1);
    localparam int SH_W              = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;

    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned ONE_Q30 = 64'd1073741824;

    localparam logic [31:0] HASH_MUL_X = 32'd57;
    localparam logic [31:0] HASH_MUL_Z = 32'd227;
    localparam logic [32:0] HASH_K1    = 33'd15731;
    localparam logic [31:0] HASH_K2    = 32'd789221;
    localparam logic [31:0] HASH_K3    = 32'd1376312589;
    localparam logic [31:0] HASH_MASK  = 32'h7fffffff;

    // register indexes
    localparam logic [1:0] REG_GAIN = 2'd0;
    localparam logic [1:0] REG_OCTS = 2'd1;
    localparam logic [1:0] REG_FREQ = 2'd2;

    // shared multiplier operations
    localparam logic [2:0] MUL_NONE  = 3'd0;
    localparam logic [2:0] MUL_SCALE = 3'd1;
    localparam logic [2:0] MUL_SQ    = 3'd2;
    localparam logic [2:0] MUL_K     = 3'd3;
    localparam logic [2:0] MUL_NH    = 3'd4;
    localparam logic [2:0] MUL_BLEND = 3'd5;
    localparam logic [2:0] MUL_ACC   = 3'd6;
    localparam logic [2:0] MUL_AMP   = 3'd7;

    typedef struct packed {
        logic             load;
        logic [2:0]       mul_op;
        logic [1:0]       ax;
        logic             cap_prod;
        logic             oct_setup;
        logic [OCT_W-1:0] oct;
        logic [2:0]       corner;
        logic             store_n;
        logic             push_corner;
        logic             pop2;
        logic             blend_push;
        logic [1:0]       wsel;
        logic             acc_add;
        logic             amp_upd;
        logic             out_load;
    } t_cmd;

    function automatic longint unsigned f_div_term(longint unsigned mag, int n);
        longint unsigned r;
        r = mag;
        unique case (n)
            1: r = mag / 64'd2;
            2: r = mag / 64'd12;
            3: r = mag / 64'd30;
            4: r = mag / 64'd56;
            5: r = mag / 64'd90;
            6: r = mag / 64'd132;
            7: r = mag / 64'd182;
            default: r = mag / 64'd240;
        endcase
        return r;
    endfunction

    function automatic longint f_cos_q30(int k);
        longint unsigned theta;
        longint unsigned t2;
        longint unsigned mag;
        longint sum;
        theta = (PI_Q30 * longint'(k)) / COS_TABLE_ENTRIES;
        t2    = (theta * theta) >> 30;
        mag   = ONE_Q30;
        sum   = longint'(ONE_Q30);
        for (int n = 1; n <= 8; n++) begin
            mag = f_div_term((mag * t2) >> 30, n);
            if (n % 2 == 1) sum = sum - longint'(mag);
            else            sum = sum + longint'(mag);
        end
        return sum;
    endfunction

    function automatic logic [COS_TABLE_ENTRIES*16-1:0] f_build_tab();
        logic [COS_TABLE_ENTRIES*16-1:0] tab;
        longint c;
        longint num;
        longint w;
        tab = '0;
        for (int k = 0; k < COS_TABLE_ENTRIES; k++) begin
            if (2 * k <= COS_TABLE_ENTRIES) c = f_cos_q30(k);
            else                            c = -f_cos_q30(COS_TABLE_ENTRIES - k);
            num = longint'(ONE_Q30) - c + 64'sd32768;
            if (num < 0) num = 0;
            w = num >>> 16;
            if (w > 32768) w = 32768;
            tab[k*16 +: 16] = w[15:0];
        end
        return tab;
    endfunction

    localparam logic [COS_TABLE_ENTRIES*16-1:0] COS_TAB = f_build_tab();

endpackage

FILE: rtl/fvn3d_ctrl.sv
// sequencer for the noise block: input/output handshake, octave, corner and blend counters
// depends on fvn3d_pkg
module fvn3d_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    input  logic [4:0]             i_octave_count,
    output fvn3d_pkg::t_cmd        o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SCL_MUL = 4'd1;
    localparam logic [3:0] S_SCL_CAP = 4'd2;
    localparam logic [3:0] S_OCT     = 4'd3;
    localparam logic [3:0] S_H1      = 4'd4;
    localparam logic [3:0] S_H2      = 4'd5;
    localparam logic [3:0] S_H3      = 4'd6;
    localparam logic [3:0] S_H4      = 4'd7;
    localparam logic [3:0] S_B1      = 4'd8;
    localparam logic [3:0] S_B2      = 4'd9;
    localparam logic [3:0] S_A1      = 4'd10;
    localparam logic [3:0] S_A2      = 4'd11;
    localparam logic [3:0] S_A3      = 4'd12;
    localparam logic [3:0] S_DONE    = 4'd13;

    logic [3:0]                  r_state, n_state;
    logic [1:0]                  r_ax, n_ax;
    logic [fvn3d_pkg::OCT_W-1:0] r_oct, n_oct;
    logic [2:0]                  r_corner, n_corner;
    logic [2:0]                  r_blend, n_blend;
    logic                        r_oval, n_oval;
    logic [fvn3d_pkg::OCT_W-1:0] octs;

    always_comb begin
        if (fvn3d_pkg::OCT_W'(i_octave_count) > fvn3d_pkg::OCT_W'(fvn3d_pkg::MAX_OCTAVES))
            octs = fvn3d_pkg::OCT_W'(fvn3d_pkg::MAX_OCTAVES);
        else
            octs = fvn3d_pkg::OCT_W'(i_octave_count);
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_oval;

    always_comb begin
        n_state  = r_state;
        n_ax     = r_ax;
        n_oct    = r_oct;
        n_corner = r_corner;
        n_blend  = r_blend;
        o_cmd        = '0;
        o_cmd.ax     = r_ax;
        o_cmd.oct    = r_oct;
        o_cmd.corner = r_corner;
        if (r_blend < 3'd4)      o_cmd.wsel = 2'd0;
        else if (r_blend < 3'd6) o_cmd.wsel = 2'd1;
        else                     o_cmd.wsel = 2'd2;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_ax       = 2'd0;
                    n_oct      = '0;
                    n_state    = S_SCL_MUL;
                end
            end
            S_SCL_MUL: begin
                o_cmd.mul_op = fvn3d_pkg::MUL_SCALE;
                n_state      = S_SCL_CAP;
            end
            S_SCL_CAP: begin
                o_cmd.cap_prod = 1'b1;
                n_ax           = r_ax + 2'd1;
                n_state        = (r_ax == 2'd2) ? S_OCT : S_SCL_MUL;
            end
            S_OCT: begin
                if (r_oct == octs) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.oct_setup = 1'b1;
                    n_corner        = 3'd0;
                    n_blend         = 3'd0;
                    n_state         = S_H1;
                end
            end
            S_H1: begin
                o_cmd.mul_op  = fvn3d_pkg::MUL_SQ;
                o_cmd.store_n = 1'b1;
                n_state       = S_H2;
            end
            S_H2: begin
                o_cmd.mul_op = fvn3d_pkg::MUL_K;
                n_state      = S_H3;
            end
            S_H3: begin
                o_cmd.mul_op = fvn3d_pkg::MUL_NH;
                n_state      = S_H4;
            end
            S_H4: begin
                o_cmd.push_corner = 1'b1;
                n_corner          = r_corner + 3'd1;
                n_state           = (r_corner == 3'd7) ? S_B1 : S_H1;
            end
            S_B1: begin
                o_cmd.mul_op = fvn3d_pkg::MUL_BLEND;
                o_cmd.pop2   = 1'b1;
                n_state      = S_B2;
            end
            S_B2: begin
                o_cmd.blend_push = 1'b1;
                n_blend          = r_blend + 3'd1;
                n_state          = (r_blend == 3'd6) ? S_A1 : S_B1;
            end
            S_A1: begin
                o_cmd.mul_op = fvn3d_pkg::MUL_ACC;
                n_state      = S_A2;
            end
            S_A2: begin
                o_cmd.acc_add = 1'b1;
                o_cmd.mul_op  = fvn3d_pkg::MUL_AMP;
                n_state       = S_A3;
            end
            S_A3: begin
                o_cmd.amp_upd = 1'b1;
                n_oct         = r_oct + fvn3d_pkg::OCT_W'(1);
                n_state       = S_OCT;
            end
            S_DONE: begin
                if (!r_oval || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_oval = r_oval;
        if (o_cmd.out_load)            n_oval = 1'b1;
        else if (r_oval && i_out_ready) n_oval = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ax     <= '0;
            r_oct    <= '0;
            r_corner <= '0;
            r_blend  <= '0;
            r_oval   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ax     <= n_ax;
            r_oct    <= n_oct;
            r_corner <= n_corner;
            r_blend  <= n_blend;
            r_oval   <= n_oval;
        end
    end

endmodule

FILE: rtl/fvn3d_dp.sv
// datapath: shared multiplier, lattice hash, cosine weights, blend queue, octave accumulator
// depends on fvn3d_pkg; driven by fvn3d_ctrl
module fvn3d_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fvn3d_pkg::t_cmd   i_cmd,
    input  logic [95:0]       i_pos,
    input  logic [15:0]       i_gain,
    input  logic [31:0]       i_freq,
    output logic [15:0]       o_noise
);

    localparam int IDXW = fvn3d_pkg::IDX_W;

    logic [31:0]        r_pos  [3];
    logic [63:0]        r_prod [3];
    logic [31:0]        r_cell [3];
    logic [15:0]        r_w    [3];
    logic [65:0]        r_mul;
    logic [31:0]        r_n;
    logic signed [31:0] r_q    [8];
    logic [3:0]         r_qcnt;
    logic signed [31:0] r_a;
    logic signed [63:0] r_sum;
    logic [31:0]        r_amp;
    logic [15:0]        r_out;

    logic [31:0]        mag    [3];
    logic               neg    [3];
    logic [31:0]        cell_n [3];
    logic [15:0]        w_n    [3];
    logic [63:0]        sh     [3];
    logic [IDXW-1:0]    idx    [3];
    logic [31:0]        hx, hy, hz, n0, n1;
    logic [31:0]        h1;
    logic [30:0]        hfin;
    logic signed [31:0] corner_val, blend_val, push_val;
    logic signed [32:0] mul_a, mul_b;
    logic [15:0]        wsel_w;
    logic [33:0]        amp_p;
    logic signed [63:0] rnd;
    logic signed [47:0] rq;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            neg[a]    = r_pos[a][31];
            mag[a]    = neg[a] ? (32'd0 - r_pos[a]) : r_pos[a];
            sh[a]     = r_prod[a] << i_cmd.oct[fvn3d_pkg::SH_W-1:0];
            cell_n[a] = neg[a] ? (32'd0 - sh[a][63:32]) : sh[a][63:32];
            idx[a]    = sh[a][31 -: IDXW];
            w_n[a]    = fvn3d_pkg::COS_TAB[idx[a]*16 +: 16];
        end
    end

    // corner hash
    always_comb begin
        hx = r_cell[0] + {31'd0, i_cmd.corner[0]};
        hy = r_cell[1] + {31'd0, i_cmd.corner[1]};
        hz = r_cell[2] + {31'd0, i_cmd.corner[2]};
        n0 = hx + hy * fvn3d_pkg::HASH_MUL_X + hz * fvn3d_pkg::HASH_MUL_Z;
        n1 = (n0 << 13) ^ n0;
        h1 = r_mul[31:0] + fvn3d_pkg::HASH_K2;
        hfin = 31'((r_mul[31:0] + fvn3d_pkg::HASH_K3) & fvn3d_pkg::HASH_MASK);
        corner_val = 32'sd1073741824 - $signed({1'b0, hfin});
        blend_val  = r_a + $signed(r_mul[46:15]);
        push_val   = i_cmd.blend_push ? blend_val : corner_val;
    end

    always_comb begin
        unique case (i_cmd.wsel)
            2'd0:    wsel_w = r_w[0];
            2'd1:    wsel_w = r_w[1];
            default: wsel_w = r_w[2];
        endcase
    end

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.mul_op)
            fvn3d_pkg::MUL_SCALE: begin
                mul_a = $signed({1'b0, mag[i_cmd.ax]});
                mul_b = $signed({1'b0, i_freq});
            end
            fvn3d_pkg::MUL_SQ: begin
                mul_a = $signed({1'b0, n1});
                mul_b = $signed({1'b0, n1});
            end
            fvn3d_pkg::MUL_K: begin
                mul_a = $signed({1'b0, r_mul[31:0]});
                mul_b = $signed(fvn3d_pkg::HASH_K1);
            end
            fvn3d_pkg::MUL_NH: begin
                mul_a = $signed({1'b0, r_n});
                mul_b = $signed({1'b0, h1});
            end
            fvn3d_pkg::MUL_BLEND: begin
                mul_a = 33'(r_q[1]) - 33'(r_q[0]);
                mul_b = $signed({17'd0, wsel_w});
            end
            fvn3d_pkg::MUL_ACC: begin
                mul_a = 33'(r_q[0]);
                mul_b = $signed({1'b0, r_amp});
            end
            fvn3d_pkg::MUL_AMP: begin
                mul_a = $signed({1'b0, r_amp});
                mul_b = $signed({17'd0, i_gain});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        amp_p = r_mul[47:14];
        rnd   = r_sum + 64'sd32768;
        rq    = rnd[63:16];
    end

    always_ff @(posedge i_clk) begin
        r_mul <= 66'(mul_a) * 66'(mul_b);
        if (i_cmd.load) begin
            r_pos[0] <= i_pos[31:0];
            r_pos[1] <= i_pos[63:32];
            r_pos[2] <= i_pos[95:64];
            r_sum    <= '0;
            r_amp    <= 32'd16384;
        end
        if (i_cmd.cap_prod) r_prod[i_cmd.ax] <= r_mul[63:0];
        if (i_cmd.oct_setup) begin
            for (int a = 0; a < 3; a++) begin
                r_cell[a] <= cell_n[a];
                r_w[a]    <= w_n[a];
            end
        end
        if (i_cmd.store_n) r_n <= n1;
        if (i_cmd.pop2) begin
            r_a <= r_q[0];
            for (int i = 0; i < 6; i++) r_q[i] <= r_q[i+2];
        end else if (i_cmd.push_corner || i_cmd.blend_push) begin
            r_q[r_qcnt[2:0]] <= push_val;
        end
        if (i_cmd.acc_add) r_sum <= r_sum + 64'($signed(r_mul[65:14]));
        if (i_cmd.amp_upd) r_amp <= (amp_p[33:32] != 2'd0) ? 32'hffffffff : amp_p[31:0];
        if (i_cmd.out_load) begin
            if (rq > 48'sd16384)       r_out <= 16'sd16384;
            else if (rq < -48'sd16384) r_out <= -16'sd16384;
            else                       r_out <= rq[15:0];
        end
    end

    // queue fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.oct_setup) r_qcnt <= '0;
        else if (i_cmd.pop2)             r_qcnt <= r_qcnt - 4'd2;
        else if (i_cmd.push_corner || i_cmd.blend_push) r_qcnt <= r_qcnt + 4'd1;
    end

    assign o_noise = r_out;

endmodule

FILE: rtl/fractal_value_noise_3d.sv
// top level of the fractal 3d value noise block: configuration registers and wiring
// depends on fvn3d_pkg, fvn3d_ctrl, fvn3d_dp
//
//   channel   direction  beat contents
//   s_axis    in         tdata: pos_x [31:0], pos_y [63:32], pos_z [95:64]
//   m_axis    out        tdata: noise_value [15:0]
//   cfg       in         index 0 persistence_gain, 1 octave_count, 2 base_frequency
//
// the single shared multiplier serialises each point: per octave a setup step, a hash
// for each corner, the blends, then amplitude and sum; a new point is taken only after
// the previous result has been loaded into the output register.
// reset returns the sequencer to idle and the registers to their defaults.
// a new point is taken while the previous result waits on m_axis; the block holds
// the next result until the output register is free.
module fractal_value_noise_3d (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [95:0] i_s_axis_tdata,   // pos_x, pos_y, pos_z
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // noise_value
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [15:0]     r_gain;
    logic [4:0]      r_octs;
    logic [31:0]     r_freq;
    fvn3d_pkg::t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= 16'd8192;
            r_octs <= 5'd4;
            r_freq <= 32'd65536;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fvn3d_pkg::REG_GAIN: r_gain <= i_cfg_data[15:0];
                fvn3d_pkg::REG_OCTS: r_octs <= i_cfg_data[4:0];
                fvn3d_pkg::REG_FREQ: r_freq <= i_cfg_data;
                default: ;
            endcase
        end
    end

    fvn3d_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_s_axis_tvalid),
        .o_in_ready     (o_s_axis_tready),
        .o_out_valid    (o_m_axis_tvalid),
        .i_out_ready    (i_m_axis_tready),
        .i_octave_count (r_octs),
        .o_cmd          (cmd)
    );

    fvn3d_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_pos   (i_s_axis_tdata),
        .i_gain  (r_gain),
        .i_freq  (r_freq),
        .o_noise (o_m_axis_tdata)
    );

endmodule
